[rtl/core/pfla_pkg.sv]
// ----------------------------------------------------------------------------
// pfla_pkg
// shared types and codes of the page free-list allocator
// ----------------------------------------------------------------------------
package pfla_pkg;

  // fixed field widths
  localparam int OP_W  = 3;
  localparam int IDX_W = 12;
  localparam int ST_W  = 3;
  localparam int PG_W  = 10;

  // request codes
  localparam logic [OP_W-1:0] OP_ALLOC   = 3'd0;
  localparam logic [OP_W-1:0] OP_DISPOSE = 3'd1;
  localparam logic [OP_W-1:0] OP_CHECK   = 3'd2;
  localparam logic [OP_W-1:0] OP_NEXT    = 3'd3;
  localparam logic [OP_W-1:0] OP_PREV    = 3'd4;

  // register index of the file-open control bit
  localparam logic REG_FILE_OPEN = 1'b0;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 3'd0,
    ST_CLOSED  = 3'd1,
    ST_INVALID = 3'd2,
    ST_FREE    = 3'd3,
    ST_NOTFND  = 3'd4,
    ST_NOROOM  = 3'd5
  } status_t;

  // step applied by the shared page-pointer unit
  typedef enum logic [1:0] {
    STEP_HOLD = 2'd0,
    STEP_INC  = 2'd1,
    STEP_DEC  = 2'd2
  } step_t;

  // compare results of the shared page-pointer unit
  typedef struct packed {
    logic in_file;   // 0 <= result < page count
    logic nonneg;    // result >= 0
    logic at_count;  // result == page count
  } alu_flags_t;

endpackage

[rtl/core/pfla_ram.sv]
// ----------------------------------------------------------------------------
// pfla_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module pfla_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/pfla_alu.sv]
// ----------------------------------------------------------------------------
// pfla_alu
// shared page-pointer unit: one increment/decrement and range compare
// ----------------------------------------------------------------------------
module pfla_alu
  import pfla_pkg::*;
#(
  parameter int SW = 13,
  parameter int CW = 11
) (
  input  logic signed [SW-1:0] operand,
  input  step_t                step,
  input  logic        [CW-1:0] count,
  output logic signed [SW-1:0] sum,
  output alu_flags_t           flags
);

  logic signed [SW-1:0] delta;
  logic signed [SW-1:0] cnt_s;

  always_comb begin
    case (step)
      STEP_INC: delta = SW'(signed'(2'sd1));
      STEP_DEC: delta = SW'(signed'(2'sb11));
      default:  delta = '0;
    endcase
  end

  assign cnt_s = signed'(SW'(count));
  assign sum   = operand + delta;

  assign flags.nonneg   = ~sum[SW-1];
  assign flags.in_file  = ~sum[SW-1] && (sum < cnt_s);
  assign flags.at_count = (sum == cnt_s);

endmodule

[rtl/core/page_free_list_allocator.sv]
// ----------------------------------------------------------------------------
// page_free_list_allocator
// sequence: allocate, dispose and check pass start, eval and done from accept
//   to result (new-page allocate, closed file and bad requests: start, done);
//   a next/prev scan runs start, then step and eval per page visited, and one
//   more step when it runs off the end; one request at a time, in_ready returns
//   once the result is parked in the output register, which can wait on out_ready
// reset: synchronous, active low; empty free list, zero pages, file closed;
//   the page link ram is not cleared, every entry is written before use
// ----------------------------------------------------------------------------
module page_free_list_allocator
  import pfla_pkg::*;
#(
  parameter int MAX_PAGES = 1024
) (
  input  logic                    clk,
  input  logic                    rst_n,

  // request channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [OP_W-1:0]         in_op,
  input  logic signed [IDX_W-1:0] in_page_index,

  // result channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [ST_W-1:0]         out_status,
  output logic [PG_W-1:0]         out_page_number,

  // apb-style configuration port
  input  logic                    cfg_psel,
  input  logic                    cfg_penable,
  input  logic                    cfg_pwrite,
  input  logic [2:0]              cfg_paddr,
  input  logic [31:0]             cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready
);

  // widths derived from the page count
  localparam int AW = $clog2(MAX_PAGES);        // ram address
  localparam int LW = $clog2(MAX_PAGES + 2);    // link word: page, end, used
  localparam int CW = $clog2(MAX_PAGES + 1);    // page count 0..MAX_PAGES
  localparam int SW = ((CW > IDX_W) ? CW : IDX_W) + 1;  // signed scan pointer

  localparam logic [LW-1:0] LINK_END  = LW'(MAX_PAGES);
  localparam logic [LW-1:0] LINK_USED = LW'(MAX_PAGES + 1);
  localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_PAGES);

  // one-hot sequencer
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,  // waiting for a request beat
    S_START = 5'b00010,  // decode request, range check, issue first access
    S_STEP  = 5'b00100,  // move scan pointer one page, issue link read
    S_EVAL  = 5'b01000,  // link word back from ram, update and decide
    S_DONE  = 5'b10000   // hand result to the output register
  } state_t;

  state_t                state_r, state_nxt;
  logic [OP_W-1:0]       op_r, op_nxt;
  logic signed [SW-1:0]  ptr_r, ptr_nxt;
  logic [LW-1:0]         head_r, head_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic                  file_open_r;
  status_t               res_st_r, res_st_nxt;
  logic [PG_W-1:0]       res_pg_r, res_pg_nxt;
  logic                  out_valid_r;
  logic [ST_W-1:0]       out_st_r;
  logic [PG_W-1:0]       out_pg_r;

  // ram port signals
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [LW-1:0]         ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [LW-1:0]         ram_rdata;

  // shared pointer unit
  step_t                 alu_step;
  logic signed [SW-1:0]  alu_sum;
  alu_flags_t            alu_flags;

  logic                  in_fire;
  logic                  out_fire;
  logic                  out_load;
  logic                  cfg_wr;
  logic                  link_used;
  logic                  scan_in_range;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // ---------------------------------------------------------------------------
  // configuration: only the file-open bit, any write with paddr[2] clear hits it
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_FILE_OPEN) ? {31'b0, file_open_r} : '0;

  // ---------------------------------------------------------------------------
  // page link store: one word per page, written before it is ever read
  // ---------------------------------------------------------------------------
  pfla_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_PAGES)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // single adder/comparator shared by range checks and both scan directions
  pfla_alu #(
    .SW (SW),
    .CW (CW)
  ) u_alu (
    .operand (ptr_r),
    .step    (alu_step),
    .count   (count_r),
    .sum     (alu_sum),
    .flags   (alu_flags)
  );

  assign link_used     = (ram_rdata == LINK_USED);
  // next scan stops past the last page, prev scan stops below page zero
  assign scan_in_range = (op_r == OP_NEXT) ? alu_flags.in_file : alu_flags.nonneg;

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    ptr_nxt    = ptr_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    res_st_nxt = res_st_r;
    res_pg_nxt = res_pg_r;
    ram_we     = 1'b0;
    ram_waddr  = ptr_r[AW-1:0];
    ram_wdata  = LINK_USED;
    ram_re     = 1'b0;
    ram_raddr  = ptr_r[AW-1:0];
    alu_step   = STEP_HOLD;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt    = in_op;
          ptr_nxt   = SW'(in_page_index);  // sign extended
          state_nxt = S_START;
        end
      end

      S_START: begin
        res_pg_nxt = '0;
        state_nxt  = S_DONE;
        if (!file_open_r) begin
          res_st_nxt = ST_CLOSED;
        end else begin
          case (op_r)
            OP_ALLOC: begin
              if (head_r < LINK_END) begin
                // pop: fetch the link of the head page
                ram_re    = 1'b1;
                ram_raddr = head_r[AW-1:0];
                state_nxt = S_EVAL;
              end else if (count_r == COUNT_MAX) begin
                res_st_nxt = ST_NOROOM;
              end else begin
                // empty list: take a fresh page
                ram_we     = 1'b1;
                ram_waddr  = count_r[AW-1:0];
                ram_wdata  = LINK_USED;
                count_nxt  = count_r + 1'b1;
                res_st_nxt = ST_OK;
                res_pg_nxt = PG_W'(count_r);
              end
            end
            OP_DISPOSE, OP_CHECK: begin
              if (alu_flags.in_file) begin
                ram_re    = 1'b1;
                state_nxt = S_EVAL;
              end else begin
                res_st_nxt = ST_INVALID;
              end
            end
            OP_NEXT: begin
              // start just before page zero or at any existing page
              if ((ptr_r == '1) || alu_flags.in_file) begin
                state_nxt = S_STEP;
              end else begin
                res_st_nxt = ST_INVALID;
              end
            end
            OP_PREV: begin
              // start just past the last page or at any existing page
              if (alu_flags.at_count || alu_flags.in_file) begin
                state_nxt = S_STEP;
              end else begin
                res_st_nxt = ST_INVALID;
              end
            end
            default: begin
              res_st_nxt = ST_INVALID;
            end
          endcase
        end
      end

      S_STEP: begin
        alu_step = (op_r == OP_NEXT) ? STEP_INC : STEP_DEC;
        ptr_nxt  = alu_sum;
        if (scan_in_range) begin
          ram_re    = 1'b1;
          ram_raddr = alu_sum[AW-1:0];
          state_nxt = S_EVAL;
        end else begin
          res_st_nxt = ST_NOTFND;
          res_pg_nxt = '0;
          state_nxt  = S_DONE;
        end
      end

      S_EVAL: begin
        state_nxt  = S_DONE;
        res_pg_nxt = '0;
        case (op_r)
          OP_ALLOC: begin
            ram_we     = 1'b1;
            ram_waddr  = head_r[AW-1:0];
            ram_wdata  = LINK_USED;
            // a used or stray mark on the head page ends the list
            head_nxt   = (ram_rdata > LINK_END) ? LINK_END : ram_rdata;
            res_st_nxt = ST_OK;
            res_pg_nxt = PG_W'(head_r[AW-1:0]);
          end
          OP_DISPOSE: begin
            if (link_used) begin
              // push onto the head of the free list
              ram_we     = 1'b1;
              ram_waddr  = ptr_r[AW-1:0];
              ram_wdata  = head_r;
              head_nxt   = LW'(ptr_r[AW-1:0]);
              res_st_nxt = ST_OK;
            end else begin
              res_st_nxt = ST_FREE;
            end
          end
          OP_CHECK: begin
            if (link_used) begin
              res_st_nxt = ST_OK;
              res_pg_nxt = PG_W'(ptr_r[AW-1:0]);
            end else begin
              res_st_nxt = ST_INVALID;
            end
          end
          default: begin
            // next / prev scan: stop on a used page, else keep walking
            if (link_used) begin
              res_st_nxt = ST_OK;
              res_pg_nxt = PG_W'(ptr_r[AW-1:0]);
            end else begin
              state_nxt = S_STEP;
            end
          end
        endcase
      end

      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= LINK_END;
      count_r     <= '0;
      file_open_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      if (cfg_wr && (cfg_paddr[2] == REG_FILE_OPEN)) begin
        file_open_r <= cfg_pwdata[0];
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    ptr_r    <= ptr_nxt;
    res_st_r <= res_st_nxt;
    res_pg_r <= res_pg_nxt;
    if (out_load) begin
      out_st_r <= res_st_r;
      out_pg_r <= res_pg_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_st_r;
  assign out_page_number = out_pg_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_MAX)
    else $error("page count beyond file size");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= LINK_END)
    else $error("free list head out of range");

  a_closed_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !file_open_r |=> ##1 (state_r == S_DONE) && (res_st_r == ST_CLOSED))
    else $error("closed file request did not answer closed");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ((state_r == S_START) || (state_r == S_EVAL)) && file_open_r)
    else $error("link ram written outside a served request");

endmodule
